// ----- sv/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition must hold in the same cycle as the trigger
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// condition must never hold
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- sv/cvmm_pkg.sv -----
// types, constants and helpers of the cv modulation matrix
// no dependencies
`default_nettype none

package cvmm_pkg;

   localparam int MAX_JACKS   = 16;
   localparam int MAX_PAGES   = 8;
   localparam int MAX_POTS    = 16;
   localparam int CELLS       = MAX_PAGES * MAX_POTS;
   localparam int JACK_W      = (MAX_JACKS > 1) ? $clog2(MAX_JACKS) : 1;
   localparam int CELL_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [4:0] ACTIVE_JACKS_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_ROUTE  = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_QUERY  = 2'd2
   } opcode_type;

   typedef enum logic {
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   // stored routing of one jack (the on/off flag is kept apart)
   typedef struct packed {
      logic [7:0]         page;
      logic [7:0]         pot;
      logic signed [15:0] gain;
      logic               bipolar;
   } route_type;

   // work handed from front to back
   typedef struct packed {
      logic               clear;
      logic               accum;
      logic               query;
      logic               hit;
      logic [CELL_W-1:0]  cell_idx;
      logic [15:0]        cv;
      logic signed [15:0] gain;
      logic               bipolar;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic pop;
      logic query_done;
   } bk_status_type;

   function automatic logic [CELL_W-1:0] cell_of(input logic [7:0] page,
                                                 input logic [7:0] pot);
      return CELL_W'(32'(page) * MAX_POTS + 32'(pot));
   endfunction

   function automatic logic target_ok(input logic [7:0] page, input logic [7:0] pot);
      return (page < 8'(MAX_PAGES)) && (pot < 8'(MAX_POTS));
   endfunction

endpackage

`default_nettype wire

// ----- sv/cv_modulation_matrix_accumulate.sv -----
// top level of the cv modulation matrix: front, command queue, back
// depends on cvmm_pkg, cvmm_front, cvmm_queue, cvmm_back, assert_macros.svh
//
//   port group   dir   handshake            carries
//   req_*        in    req_valid/req_stall  one route write, cv sample or query word
//   rsp_*        out   rsp_valid/rsp_stall  delta of the queried cell
//   csr_*        in    csr_valid/csr_ready  number of jacks in use (always ready)
//
// front takes a word when the queue has room; route writes finish there
// back handles each queued command in its idle then exec state: cell memory read
// plus 17x16 multiply, then round, saturating add and write back; the back end's
// read-then-write of the cell memory lets no new sample or query in until it is done
// a query also waits in the back until the result register is free
// reset is synchronous: route flags off, all cells read as zero, jack count 16
`default_nettype none
`include "assert_macros.svh"

module cv_modulation_matrix_accumulate (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_active_jacks,
   // request words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [7:0]         req_jack_index,
   input  logic [15:0]        req_cv_sample,
   input  logic               req_frame_start,
   input  logic               req_route_to_knob,
   input  logic [7:0]         req_target_page,
   input  logic [7:0]         req_target_pot,
   input  logic signed [15:0] req_attenuation,
   input  logic               req_bipolar_mode,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_delta_value
);

   cvmm_pkg::q_status_type  q_status;
   cvmm_pkg::bk_status_type bk_status;
   cvmm_pkg::cmd_type       push_cmd;
   cvmm_pkg::cmd_type       head_cmd;
   logic                    push;

   // classification, route table and jack count
   cvmm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_active_jacks  (csr_active_jacks),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_jack_index    (req_jack_index),
      .req_cv_sample     (req_cv_sample),
      .req_frame_start   (req_frame_start),
      .req_route_to_knob (req_route_to_knob),
      .req_target_page   (req_target_page),
      .req_target_pot    (req_target_pot),
      .req_attenuation   (req_attenuation),
      .req_bipolar_mode  (req_bipolar_mode),
      .q_status          (q_status),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   // decouples front and back so each can stall on its own
   cvmm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (bk_status.pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   // cell memory, accumulate and result register
   cvmm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .q_status        (q_status),
      .bk_status       (bk_status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_delta_value (rsp_delta_value)
   );

   // queue can not look full and empty at once
   `ASSERT_NEVER(a_queue_state, clock, reset, q_status.full && q_status.empty)
   // front never pushes into a full queue
   `ASSERT_NEVER(a_no_overflow, clock, reset, push && q_status.full)
   // back never pops an empty queue
   `ASSERT_NEVER(a_no_underflow, clock, reset, bk_status.pop && q_status.empty)
   // a finished query shows up on the result port next cycle
   `ASSERT_NEXT(a_query_shown, clock, reset, bk_status.query_done, rsp_valid)

endmodule

`default_nettype wire

// ----- sv/cvmm_queue.sv -----
// short command queue between front and back
// depends on cvmm_pkg
`default_nettype none

module cvmm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cvmm_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output cvmm_pkg::cmd_type      head_cmd,
   output cvmm_pkg::q_status_type q_status
);

   cvmm_pkg::cmd_type                entries_ff [cvmm_pkg::QUEUE_DEPTH];
   logic [cvmm_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [cvmm_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [cvmm_pkg::QCNT_W-1:0]      count_ff, count_in;

   function automatic logic [cvmm_pkg::QPTR_W-1:0] bump(
      input logic [cvmm_pkg::QPTR_W-1:0] p);
      if (p == cvmm_pkg::QPTR_W'(cvmm_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd       = entries_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == cvmm_pkg::QCNT_W'(cvmm_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ----- sv/cvmm_front.sv -----
// front end: accepts words, keeps the route table and jack count,
// turns samples and queries into commands; depends on cvmm_pkg
`default_nettype none

module cvmm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [4:0]             csr_active_jacks,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic [7:0]             req_jack_index,
   input  logic [15:0]            req_cv_sample,
   input  logic                   req_frame_start,
   input  logic                   req_route_to_knob,
   input  logic [7:0]             req_target_page,
   input  logic [7:0]             req_target_pot,
   input  logic signed [15:0]     req_attenuation,
   input  logic                   req_bipolar_mode,
   input  cvmm_pkg::q_status_type q_status,
   output logic                   push,
   output cvmm_pkg::cmd_type      push_cmd
);

   logic [4:0]                        active_ff, active_in;
   logic [cvmm_pkg::MAX_JACKS-1:0]    knob_ff, knob_in;
   cvmm_pkg::route_type               route_ff [cvmm_pkg::MAX_JACKS];
   cvmm_pkg::route_type               route_in;
   logic                              route_we;
   logic                              accept;
   logic                              jack_ok;
   logic [cvmm_pkg::JACK_W-1:0]       jack_sel;
   cvmm_pkg::route_type               rd_route;
   logic                              rd_knob;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   assign active_in = (csr_valid && csr_ready) ? csr_active_jacks : active_ff;

   assign jack_ok  = (req_jack_index < 8'(active_ff)) &&
                     (req_jack_index < 8'(cvmm_pkg::MAX_JACKS));
   assign jack_sel = req_jack_index[cvmm_pkg::JACK_W-1:0];
   assign rd_route = route_ff[jack_sel];
   assign rd_knob  = knob_ff[jack_sel];

   assign route_in.page    = req_target_page;
   assign route_in.pot     = req_target_pot;
   assign route_in.gain    = req_attenuation;
   assign route_in.bipolar = req_bipolar_mode;

   always_comb begin
      route_we = 1'b0;
      push     = 1'b0;
      push_cmd = '0;
      case (cvmm_pkg::opcode_type'(req_opcode))
         cvmm_pkg::OP_ROUTE: begin
            route_we = accept && jack_ok;
         end
         cvmm_pkg::OP_SAMPLE: begin
            push_cmd.clear    = req_frame_start;
            push_cmd.accum    = jack_ok && rd_knob &&
                                cvmm_pkg::target_ok(rd_route.page, rd_route.pot);
            push_cmd.cell_idx = cvmm_pkg::cell_of(rd_route.page, rd_route.pot);
            push_cmd.cv       = req_cv_sample;
            push_cmd.gain     = rd_route.gain;
            push_cmd.bipolar  = rd_route.bipolar;
            push              = accept && (push_cmd.clear || push_cmd.accum);
         end
         cvmm_pkg::OP_QUERY: begin
            push_cmd.query    = 1'b1;
            push_cmd.hit      = cvmm_pkg::target_ok(req_target_page, req_target_pot);
            push_cmd.cell_idx = cvmm_pkg::cell_of(req_target_page, req_target_pot);
            push              = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_comb begin
      knob_in = knob_ff;
      if (route_we) begin
         knob_in[jack_sel] = req_route_to_knob;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= cvmm_pkg::ACTIVE_JACKS_RESET;
         knob_ff   <= '0;
      end else begin
         active_ff <= active_in;
         knob_ff   <= knob_in;
      end
   end

   always_ff @(posedge clock) begin
      if (route_we) begin
         route_ff[jack_sel] <= route_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/cvmm_back.sv -----
// back end: cell memory, scale and saturating accumulate, result register
// depends on cvmm_pkg
`default_nettype none

module cvmm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  cvmm_pkg::cmd_type       head_cmd,
   input  cvmm_pkg::q_status_type  q_status,
   output cvmm_pkg::bk_status_type bk_status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_delta_value
);

   cvmm_pkg::back_state_type       state_ff, state_in;
   cvmm_pkg::cmd_type              cmd_ff;
   logic signed [32:0]             prod_ff, prod_in;
   logic [31:0]                    rd_ff;
   logic [31:0]                    delta_mem_ff [cvmm_pkg::CELLS];
   logic [cvmm_pkg::CELLS-1:0]     cell_valid_ff, cell_valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]             rsp_data_ff;
   logic                           pop;
   logic                           finish;
   logic                           out_free;
   logic signed [16:0]             v;
   logic signed [32:0]             rounded;
   logic signed [20:0]             term;
   logic signed [31:0]             old_val;
   logic signed [32:0]             sum;
   logic signed [31:0]             sat_val;
   logic signed [31:0]             query_val;
   logic                           mem_we;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cvmm_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = cvmm_pkg::BK_EXEC;
            end
         end
         cvmm_pkg::BK_EXEC: begin
            if (!cmd_ff.query || out_free) begin
               state_in = cvmm_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = cvmm_pkg::BK_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      pop    = 1'b0;
      finish = 1'b0;
      case (state_ff)
         cvmm_pkg::BK_IDLE: begin
            pop = !q_status.empty;
         end
         cvmm_pkg::BK_EXEC: begin
            finish = !cmd_ff.query || out_free;
         end
         default: begin
            pop    = 1'b0;
            finish = 1'b0;
         end
      endcase
   end

   // offset and scale on pop
   always_comb begin
      if (head_cmd.bipolar) begin
         v = $signed({1'b0, head_cmd.cv}) - 17'sd32768;
      end else begin
         v = $signed({1'b0, head_cmd.cv});
      end
      prod_in = 33'(v) * 33'(head_cmd.gain);
   end

   // round off the low 12 bits, add, saturate
   always_comb begin
      rounded = prod_ff + 33'sd2048;
      term    = rounded[32:12];
      if (cmd_ff.clear || !cell_valid_ff[cmd_ff.cell_idx]) begin
         old_val = '0;
      end else begin
         old_val = rd_ff;
      end
      sum = 33'(old_val) + 33'(term);
      if (sum > 33'sd2147483647) begin
         sat_val = 32'sh7fffffff;
      end else if (sum < -33'sd2147483648) begin
         sat_val = 32'sh80000000;
      end else begin
         sat_val = sum[31:0];
      end
      query_val = (cmd_ff.hit && cell_valid_ff[cmd_ff.cell_idx]) ? rd_ff : '0;
   end

   assign mem_we = finish && cmd_ff.accum;

   always_comb begin
      cell_valid_in = cell_valid_ff;
      if (finish && cmd_ff.clear) begin
         cell_valid_in = '0;
      end
      if (mem_we) begin
         cell_valid_in[cmd_ff.cell_idx] = 1'b1;
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || (finish && cmd_ff.query);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cvmm_pkg::BK_IDLE;
         cell_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cell_valid_ff <= cell_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff  <= head_cmd;
         prod_ff <= prod_in;
         rd_ff   <= delta_mem_ff[head_cmd.cell_idx];
      end
      if (mem_we) begin
         delta_mem_ff[cmd_ff.cell_idx] <= sat_val;
      end
      if (finish && cmd_ff.query) begin
         rsp_data_ff <= query_val;
      end
   end

   assign bk_status.pop        = pop;
   assign bk_status.query_done = finish && cmd_ff.query;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_delta_value      = rsp_data_ff;

endmodule

`default_nettype wire
